### rtl/volume_box_filter_3x3x3_top_defines.svh
// Assertion macros shared by the RTL of the volume box filter.
// Each macro checks an implication on the rising clock edge and is
// disabled while the active-low reset is asserted.
`ifndef VOLUME_BOX_FILTER_3X3X3_TOP_DEFINES_SVH
`define VOLUME_BOX_FILTER_3X3X3_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define VBF3_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication.
`define VBF3_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`else

`define VBF3_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define VBF3_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/vbf3_pkg.sv
package vbf3_pkg;

  // Volume and sample geometry.
  localparam int MaxDim     = 64;
  localparam int SampleBits = 16;
  localparam int GridBits   = 7;
  localparam int CoordBits  = $clog2(MaxDim);

  // Address spaces of the plane store and the line store.
  localparam int PlaneAddrBits = 2 * CoordBits;
  localparam int PlaneDepth    = 1 << PlaneAddrBits;
  localparam int LineDepth     = 1 << CoordBits;

  // Growth of the partial sums: three samples, nine samples, 27 samples.
  localparam int SzBits  = SampleBits + 2;
  localparam int SyzBits = SampleBits + 4;
  localparam int SumBits = SampleBits + 5;

  // Division by 27 as a multiplication by a rounded-up reciprocal.
  // The dividend stays below 2^(SampleBits+4) and the reciprocal error is
  // below 2^5, so a shift of SampleBits+9 keeps the quotient exact.
  localparam int MagBits   = SampleBits + 4;
  localparam int DivShift  = SampleBits + 9;
  localparam int RecipBits = DivShift - 4;
  localparam int ProdBits  = MagBits + RecipBits;
  localparam logic [RecipBits-1:0] RecipMult =
    RecipBits'(((64'd1 << DivShift) + 64'd26) / 64'd27);
  localparam logic [MagBits-1:0] RoundBias = MagBits'(13);

  // Smallest edge length that still holds a full window.
  localparam int MinGrid = 3;

  // Centre coordinates and end flag carried along the pipeline.
  typedef struct packed {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [CoordBits-1:0] z;
    logic                 last;
  } vbf3_centre_t;

endpackage

### rtl/volume_box_filter_3x3x3_top.sv
// Streaming 3x3x3 box filter over a cubic volume of signed Q3.12 samples.
// Input channel: in_valid_i, sample_i, in_stall_o. Samples arrive in raster
// order, x fastest, then y, then z. A transfer happens when in_valid_i is
// high and in_stall_o is low.
// Output channel: out_valid_o, centre_x_o/y_o/z_o, average_o, volume_end_o,
// out_stall_i. Only a sample that completes a window (x, y and z all at
// least 2) produces a transfer; border samples produce none.
// Configuration: cfg_valid_i, cfg_wdata_i, cfg_ready_o (always high). A
// write sets the edge length (clamped to 3..64) and restarts the raster.
// Throughput is one sample per cycle while the output is not stalled. Each
// result moves through registers in order: the input transfer loads the column
// sum over z and the two earlier rows, then come the sum over y, the window sum,
// the magnitude and the reciprocal multiplier, and the output register follows.
// Reset restarts the raster at (0,0,0) with edge length 64 and empties the
// pipeline; the sample stores are not cleared.
// While the output register holds a result and out_stall_i is high, the
// whole pipeline holds. One more input sample is caught in a skid register,
// and in_stall_o rises on the following cycle.
module volume_box_filter_3x3x3_top
  import vbf3_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write channel
  input  logic                        cfg_valid_i,
  input  logic [GridBits-1:0]         cfg_wdata_i,
  output logic                        cfg_ready_o,
  // Input channel
  input  logic                        in_valid_i,
  input  logic signed [SampleBits-1:0] sample_i,
  output logic                        in_stall_o,
  // Output channel
  output logic                        out_valid_o,
  output logic [CoordBits-1:0]        centre_x_o,
  output logic [CoordBits-1:0]        centre_y_o,
  output logic [CoordBits-1:0]        centre_z_o,
  output logic signed [SampleBits-1:0] average_o,
  output logic                        volume_end_o,
  input  logic                        out_stall_i
);

`include "volume_box_filter_3x3x3_top_defines.svh"

  // ---------------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------------
  logic                         cfg_we;
  logic [CoordBits-1:0]         edge_last_q, edge_last_d;
  logic [CoordBits-1:0]         pos_x_q, pos_y_q, pos_z_q;
  logic [CoordBits-1:0]         pos_x_d, pos_y_d, pos_z_d;
  logic                         adv;
  logic                         take;
  logic                         skid_q;
  logic signed [SampleBits-1:0] skid_sample_q;
  logic signed [SampleBits-1:0] pipe_sample;
  logic                         is_result;
  logic                         at_last_pos;
  vbf3_centre_t                 centre_d;

  logic [2*SampleBits-1:0]      plane_mem [PlaneDepth];
  logic [2*SampleBits-1:0]      plane_rd_q;
  logic [2*SzBits-1:0]          line_mem [LineDepth];
  logic [2*SzBits-1:0]          line_rd_q;
  logic signed [SampleBits-1:0] plane_p1, plane_p2;
  logic signed [SzBits-1:0]     sz;

  logic                         s1_item_q, s1_res_q;
  vbf3_centre_t                 s1_meta_q;
  logic signed [SzBits-1:0]     s1_sz_q, s1_l1_q, s1_l2_q;
  logic signed [SyzBits-1:0]    syz;

  logic                         s2_res_q;
  vbf3_centre_t                 s2_meta_q;
  logic signed [SyzBits-1:0]    syz_q, h1_q, h2_q;
  logic signed [SumBits-1:0]    sum;

  logic                         s3_res_q;
  vbf3_centre_t                 s3_meta_q;
  logic signed [SumBits-1:0]    s3_sum_q;
  logic [SumBits-1:0]           abs_sum;

  logic                         s4_res_q;
  vbf3_centre_t                 s4_meta_q;
  logic                         s4_neg_q;
  logic [MagBits-1:0]           s4_n_q;

  logic                         s5_res_q;
  vbf3_centre_t                 s5_meta_q;
  logic                         s5_neg_q;
  logic [ProdBits-1:0]          s5_prod_q;
  logic [SampleBits-1:0]        quot;

  logic                         out_valid_q;
  vbf3_centre_t                 out_meta_q;
  logic signed [SampleBits-1:0] out_avg_q;

  // ---------------------------------------------------------------------
  // Configuration: clamp the edge length and keep its last coordinate
  // ---------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    int g;
    g = int'(cfg_wdata_i);
    if (g < MinGrid) begin
      g = MinGrid;
    end else if (g > MaxDim) begin
      g = MaxDim;
    end
    edge_last_d = CoordBits'(g - 1);
  end

  // ---------------------------------------------------------------------
  // Handshake, skid register and pipeline advance
  // ---------------------------------------------------------------------
  // The pipeline moves whenever the output register is free or drained.
  assign adv         = !out_valid_q || !out_stall_i;
  assign take        = adv && (skid_q || in_valid_i);
  assign pipe_sample = skid_q ? skid_sample_q : sample_i;
  assign in_stall_o  = skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_q <= 1'b0;
    end else if (skid_q) begin
      if (adv) begin
        skid_q <= 1'b0;
      end
    end else if (in_valid_i && !adv) begin
      skid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_q && in_valid_i && !adv) begin
      skid_sample_q <= sample_i;
    end
  end

  // ---------------------------------------------------------------------
  // Raster position of the sample entering the pipeline
  // ---------------------------------------------------------------------
  assign at_last_pos = (pos_x_q == edge_last_q) && (pos_y_q == edge_last_q) &&
                       (pos_z_q == edge_last_q);

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    if (cfg_we) begin
      pos_x_d = '0;
      pos_y_d = '0;
      pos_z_d = '0;
    end else if (take) begin
      if (pos_x_q != edge_last_q) begin
        pos_x_d = pos_x_q + CoordBits'(1);
      end else begin
        pos_x_d = '0;
        if (pos_y_q != edge_last_q) begin
          pos_y_d = pos_y_q + CoordBits'(1);
        end else begin
          pos_y_d = '0;
          if (pos_z_q != edge_last_q) begin
            pos_z_d = pos_z_q + CoordBits'(1);
          end else begin
            pos_z_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      pos_z_q     <= '0;
      edge_last_q <= CoordBits'(MaxDim - 1);
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
      if (cfg_we) begin
        edge_last_q <= edge_last_d;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Plane and line stores
  // ---------------------------------------------------------------------
  // The plane store keeps the two previous planes at each (y,x) and the
  // line store the two previous column sums at each x. Both are read at
  // the next position, so the data is ready when that sample arrives.
  always_ff @(posedge clk_i) begin
    if (take) begin
      plane_mem[{pos_y_q, pos_x_q}] <= {pipe_sample, plane_p1};
    end
    plane_rd_q <= plane_mem[{pos_y_d, pos_x_d}];
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      line_mem[pos_x_q] <= {sz, line_rd_q[2*SzBits-1:SzBits]};
    end
    line_rd_q <= line_mem[pos_x_d];
  end

  // ---------------------------------------------------------------------
  // Entry stage: sum over z of the three samples at (x,y)
  // ---------------------------------------------------------------------
  assign plane_p1 = plane_rd_q[2*SampleBits-1:SampleBits];
  assign plane_p2 = plane_rd_q[SampleBits-1:0];
  assign sz       = SzBits'(pipe_sample) + SzBits'(plane_p1) + SzBits'(plane_p2);

  assign is_result = (pos_x_q >= CoordBits'(2)) && (pos_y_q >= CoordBits'(2)) &&
                     (pos_z_q >= CoordBits'(2));

  always_comb begin
    centre_d.x    = pos_x_q - CoordBits'(1);
    centre_d.y    = pos_y_q - CoordBits'(1);
    centre_d.z    = pos_z_q - CoordBits'(1);
    centre_d.last = at_last_pos;
  end

  // ---------------------------------------------------------------------
  // Pipeline valid flags
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_item_q   <= 1'b0;
      s1_res_q    <= 1'b0;
      s2_res_q    <= 1'b0;
      s3_res_q    <= 1'b0;
      s4_res_q    <= 1'b0;
      s5_res_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_item_q   <= take;
      s1_res_q    <= take && is_result;
      s2_res_q    <= s1_res_q;
      s3_res_q    <= s2_res_q;
      s4_res_q    <= s3_res_q;
      s5_res_q    <= s4_res_q;
      out_valid_q <= s5_res_q;
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline data
  // ---------------------------------------------------------------------
  assign syz = SyzBits'(s1_sz_q) + SyzBits'(s1_l1_q) + SyzBits'(s1_l2_q);
  assign sum = SumBits'(syz_q) + SumBits'(h1_q) + SumBits'(h2_q);
  assign abs_sum = s3_sum_q[SumBits-1] ? SumBits'(-s3_sum_q) : SumBits'(s3_sum_q);
  assign quot = s5_prod_q[ProdBits-1:DivShift];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Stage 1: column sum over z, plus the two earlier rows from the line store.
      if (take) begin
        s1_meta_q <= centre_d;
        s1_sz_q   <= sz;
        s1_l1_q   <= line_rd_q[2*SzBits-1:SzBits];
        s1_l2_q   <= line_rd_q[SzBits-1:0];
      end
      // Stage 2: plane sum over y and z; the x history shifts per sample.
      if (s1_item_q) begin
        s2_meta_q <= s1_meta_q;
        syz_q     <= syz;
        h1_q      <= syz_q;
        h2_q      <= h1_q;
      end
      // Stage 3: full window sum.
      s3_meta_q <= s2_meta_q;
      s3_sum_q  <= sum;
      // Stage 4: magnitude with the rounding bias.
      s4_meta_q <= s3_meta_q;
      s4_neg_q  <= s3_sum_q[SumBits-1];
      s4_n_q    <= MagBits'(abs_sum) + RoundBias;
      // Stage 5: multiply by the reciprocal of 27.
      s5_meta_q <= s4_meta_q;
      s5_neg_q  <= s4_neg_q;
      s5_prod_q <= ProdBits'(s4_n_q) * ProdBits'(RecipMult);
      // Output register: restore the sign.
      if (s5_res_q) begin
        out_meta_q <= s5_meta_q;
        out_avg_q  <= s5_neg_q ? -$signed(quot) : $signed(quot);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------
  assign out_valid_o  = out_valid_q;
  assign centre_x_o   = out_meta_q.x;
  assign centre_y_o   = out_meta_q.y;
  assign centre_z_o   = out_meta_q.z;
  assign average_o    = out_avg_q;
  assign volume_end_o = out_meta_q.last;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `VBF3_ASSERT_IMP(a_pos_in_grid, clk_i, rst_ni, 1'b1, (pos_x_q <= edge_last_q) && (pos_y_q <= edge_last_q) && (pos_z_q <= edge_last_q))
  `VBF3_ASSERT_NXT(a_raster_wraps, clk_i, rst_ni, take && at_last_pos && !cfg_we, (pos_x_q == '0) && (pos_y_q == '0) && (pos_z_q == '0))
  `VBF3_ASSERT_IMP(a_end_centre, clk_i, rst_ni, out_valid_o && volume_end_o, (centre_x_o == edge_last_q - CoordBits'(1)) && (centre_y_o == edge_last_q - CoordBits'(1)) && (centre_z_o == edge_last_q - CoordBits'(1)))
  `VBF3_ASSERT_NXT(a_skid_drains, clk_i, rst_ni, skid_q && adv, !skid_q)

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import vbf3_pkg::*;

  // Cycles allowed for the pipeline to settle once no result is pending.
  localparam int DrainCycles = 10;
  localparam int RandomItems = 1000;
  // Two rows of a 64-wide volume: too few samples to complete any window.
  localparam int LargeRunItems = 2 * MaxDim;

  // Ways of filling a stream of samples.
  typedef enum int {
    FILL_RANDOM,
    FILL_EXTREMES,
    FILL_TINY,
    FILL_NEAR_LIMIT,
    FILL_MAX,
    FILL_MIN
  } fill_mode_e;

  // One smoothed voxel: centre, end flag and rounded mean.
  typedef struct packed {
    vbf3_centre_t                centre;
    logic signed [SampleBits-1:0] mean;
  } window_mean_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic [GridBits-1:0]          cfg_wdata = '0;
  logic                         cfg_ready;
  logic                         in_valid = 1'b0;
  logic signed [SampleBits-1:0] sample = '0;
  logic                         in_stall;
  logic                         out_valid;
  logic [CoordBits-1:0]         centre_x;
  logic [CoordBits-1:0]         centre_y;
  logic [CoordBits-1:0]         centre_z;
  logic signed [SampleBits-1:0] average;
  logic                         volume_end;
  logic                         out_stall = 1'b0;

  // Idle rates of the sample source and the result sink, in percent.
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int idle_src_table[4] = '{0, 86, 0, 6};
  int idle_sink_table[4] = '{0, 0, 86, 6};

  int mismatch_count = 0;
  window_mean_t expected_windows[$];

  // Predictor state: plane store, raster position and edge length.
  logic signed [SampleBits-1:0] plane_mem[3][MaxDim][MaxDim];
  int pos_x = 0;
  int pos_y = 0;
  int pos_z = 0;
  int newest_slot = 0;
  logic [GridBits-1:0] grid_reg = GridBits'(MaxDim);

  volume_box_filter_3x3x3_top DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_wdata_i  (cfg_wdata),
    .cfg_ready_o  (cfg_ready),
    .in_valid_i   (in_valid),
    .sample_i     (sample),
    .in_stall_o   (in_stall),
    .out_valid_o  (out_valid),
    .centre_x_o   (centre_x),
    .centre_y_o   (centre_y),
    .centre_z_o   (centre_z),
    .average_o    (average),
    .volume_end_o (volume_end),
    .out_stall_i  (out_stall)
  );

  always #5 clk = ~clk;

  // Store one accepted sample and compute the window mean it completes.
  task automatic predict_window_mean(input logic signed [SampleBits-1:0] value);
    window_mean_t w;
    int side;
    int sum;
    int mag;
    int quot;
    int slot;
    int k;
    int j;
    int i;
    side = int'(grid_reg);
    if (side < MinGrid) side = MinGrid;
    if (side > MaxDim) side = MaxDim;
    plane_mem[newest_slot][pos_y][pos_x] = value;
    if (pos_x >= 2 && pos_y >= 2 && pos_z >= 2) begin
      sum = 0;
      for (k = 0; k < 3; k++) begin
        slot = (newest_slot + 3 - k) % 3;
        for (j = 0; j < 3; j++) begin
          for (i = 0; i < 3; i++) begin
            sum += plane_mem[slot][pos_y - j][pos_x - i];
          end
        end
      end
      // Round to nearest on the magnitude, so ties move away from zero.
      mag = (sum < 0) ? -sum : sum;
      quot = (mag + 13) / 27;
      w.centre.x = CoordBits'(pos_x - 1);
      w.centre.y = CoordBits'(pos_y - 1);
      w.centre.z = CoordBits'(pos_z - 1);
      w.centre.last = (pos_x == side - 1 && pos_y == side - 1 && pos_z == side - 1);
      w.mean = SampleBits'((sum < 0) ? -quot : quot);
      expected_windows.insert(expected_windows.size(), w);
    end
    // Advance the raster; a finished volume starts over at the origin.
    if (pos_x + 1 < side) begin
      pos_x++;
    end else begin
      pos_x = 0;
      if (pos_y + 1 < side) begin
        pos_y++;
      end else begin
        pos_y = 0;
        if (pos_z + 1 < side) begin
          pos_z++;
          newest_slot = (newest_slot + 1) % 3;
        end else begin
          pos_z = 0;
          newest_slot = 0;
        end
      end
    end
  endtask

  // Offer one sample, with optional idle cycles first, until the transfer.
  task automatic push_sample(input logic signed [SampleBits-1:0] value);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_window_mean(value);
  endtask

  // Send a run of samples drawn from one fill pattern.
  task automatic stream_samples(input int count, input fill_mode_e fill);
    logic signed [SampleBits-1:0] s;
    int n;
    for (n = 0; n < count; n++) begin
      case (fill)
        FILL_EXTREMES: begin
          case ($urandom_range(3))
            0: s = 16'sh7FFF;
            1: s = 16'sh8000;
            2: s = '0;
            default: s = '1;
          endcase
        end
        FILL_TINY: s = SampleBits'(int'($urandom_range(4)) - 2);
        FILL_NEAR_LIMIT: begin
          if ($urandom_range(1) == 1) s = SampleBits'(32767 - int'($urandom_range(63)));
          else s = SampleBits'(-32768 + int'($urandom_range(63)));
        end
        FILL_MAX: s = 16'sh7FFF;
        FILL_MIN: s = 16'sh8000;
        default: s = SampleBits'($urandom);
      endcase
      push_sample(s);
    end
  endtask

  // Wait until every expected result has arrived and the pipeline is empty.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_windows.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write the edge length while idle; the write also restarts the raster.
  task automatic write_grid(input logic [GridBits-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_wdata <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    grid_reg = value;
    pos_x = 0;
    pos_y = 0;
    pos_z = 0;
    newest_slot = 0;
  endtask

  // Edge length after reset is the largest one; run a couple of rows of it.
  task automatic test_default_grid();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    stream_samples(LargeRunItems, FILL_RANDOM);
  endtask

  // Full-scale samples must average back to themselves, positive and negative.
  task automatic test_extreme_samples();
    write_grid(GridBits'(3));
    stream_samples(27, FILL_MAX);
    stream_samples(27, FILL_MIN);
  endtask

  // Edge lengths below three act as three; above the maximum act as the maximum.
  task automatic test_grid_clamp();
    write_grid(GridBits'(0));
    stream_samples(27, FILL_RANDOM);
    write_grid(GridBits'(2));
    stream_samples(27, FILL_TINY);
    write_grid(GridBits'(127));
    src_idle_pct = 6;
    sink_stall_pct = 6;
    stream_samples(LargeRunItems, FILL_NEAR_LIMIT);
  endtask

  // A write in the middle of a volume throws away the partial raster.
  task automatic test_restart_mid_volume();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    write_grid(GridBits'(4));
    stream_samples(40, FILL_RANDOM);
    write_grid(GridBits'(5));
    stream_samples(125, FILL_RANDOM);
  endtask

  // Random small volumes, back to back, with some cut short, under all idle mixes.
  task automatic test_random_volumes();
    int sent;
    int phase;
    int pick;
    int side;
    int vols;
    int v;
    int cut;
    logic [GridBits-1:0] wval;
    fill_mode_e fill;
    sent = 0;
    phase = 0;
    while (sent < RandomItems) begin
      pick = $urandom_range(99);
      if (pick < 70) side = $urandom_range(3, 5);
      else if (pick < 95) side = $urandom_range(6, 7);
      else side = 8;
      wval = GridBits'(side);
      // Now and then an out-of-range low value stands in for three.
      if (side == 3 && $urandom_range(2) == 0) wval = GridBits'($urandom_range(2));
      write_grid(wval);
      vols = $urandom_range(1, 3);
      for (v = 0; v < vols; v++) begin
        // Each volume runs under the next idle mix in turn.
        src_idle_pct = idle_src_table[phase % 4];
        sink_stall_pct = idle_sink_table[phase % 4];
        phase++;
        pick = $urandom_range(99);
        if (pick < 50) fill = FILL_RANDOM;
        else if (pick < 70) fill = FILL_TINY;
        else if (pick < 85) fill = FILL_EXTREMES;
        else fill = FILL_NEAR_LIMIT;
        if ($urandom_range(9) == 0) begin
          cut = $urandom_range(1, side * side * side - 1);
          stream_samples(cut, fill);
          sent += cut;
          break;
        end
        stream_samples(side * side * side, fill);
        sent += side * side * side;
      end
    end
    src_idle_pct = 0;
    sink_stall_pct = 0;
  endtask

  // Compare each result transfer with the oldest expectation; drive the stall.
  always @(posedge clk) begin
    window_mean_t e;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_windows.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none expected: x %0d y %0d z %0d mean %0d end %0b",
                 $time, centre_x, centre_y, centre_z, average, volume_end);
      end else begin
        e = expected_windows.pop_front();
        if (centre_x !== e.centre.x) begin
          mismatch_count++;
          $display("%0t: centre_x expected %0d actual %0d", $time, e.centre.x, centre_x);
        end
        if (centre_y !== e.centre.y) begin
          mismatch_count++;
          $display("%0t: centre_y expected %0d actual %0d", $time, e.centre.y, centre_y);
        end
        if (centre_z !== e.centre.z) begin
          mismatch_count++;
          $display("%0t: centre_z expected %0d actual %0d", $time, e.centre.z, centre_z);
        end
        if (average !== e.mean) begin
          mismatch_count++;
          $display("%0t: average expected %0d actual %0d", $time, e.mean, average);
        end
        if (volume_end !== e.centre.last) begin
          mismatch_count++;
          $display("%0t: volume_end expected %0b actual %0b", $time, e.centre.last,
                   volume_end);
        end
      end
    end
    out_stall <= (sink_stall_pct != 0) && ($urandom_range(99) < sink_stall_pct);
  end

  // Main sequence: reset once, run each test, then report.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_grid();
    test_extreme_samples();
    test_grid_clamp();
    test_restart_mid_volume();
    test_random_volumes();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("PASS volume_box_filter_3x3x3_top");
    end else begin
      $display("FAIL volume_box_filter_3x3x3_top");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("FAIL volume_box_filter_3x3x3_top");
    $finish;
  end

endmodule
